/* design/dimmer_frame_receiver_unit_assert.svh */
// Assertion macros used by the receiver checker.
`ifndef DIMMER_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define DIMMER_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define DFR_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("receiver check failed");

// Next-cycle implication, disabled while reset is held.
`define DFR_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("receiver check failed");

`endif

/* design/dfr_pkg.sv */
package dfr_pkg;

    localparam int BUFFER_BYTES_DEF = 52;

    localparam logic [7:0] SYNC_FIRST  = 8'h55;
    localparam logic [7:0] SYNC_SECOND = 8'hAA;
    localparam logic [7:0] SUM_SEED    = 8'hFF;

    localparam logic [7:0]  CMD_ACK    = 8'd5;
    localparam logic [7:0]  CMD_REPORT = 8'd7;
    localparam logic [15:0] LEN_SWITCH = 16'd5;
    localparam logic [15:0] LEN_LEVEL  = 16'd8;

    localparam int POS_SWITCH   = 4;
    localparam int POS_LEVEL_HI = 6;
    localparam int POS_LEVEL_LO = 7;

    localparam logic [1:0] STATUS_GOOD     = 2'd0;
    localparam logic [1:0] STATUS_BAD      = 2'd1;
    localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

    localparam logic [1:0] REG_RAW_MIN    = 2'd0;
    localparam logic [1:0] REG_RAW_MAX    = 2'd1;
    localparam logic [1:0] REG_USER_RANGE = 2'd2;

    localparam logic [15:0] RAW_MIN_RESET    = 16'd0;
    localparam logic [15:0] RAW_MAX_RESET    = 16'd1000;
    localparam logic [7:0]  USER_RANGE_RESET = 8'd200;

endpackage

/* design/dimmer_frame_receiver_unit.sv */
// Takes one received byte per cycle while idle; a frame result is registered at its closing
// byte and can be taken from the next cycle on. Input stalls while a result waits untaken.
// A good command 7 length 8 frame maps its level first: a level at or beyond either end of
// the raw range is clamped in the map state, otherwise the map state forms the product and
// the restoring divider then builds the quotient bit by bit; input is held off meanwhile.
// Reset (aresetn low, synchronous) returns to sync hunting, drops the pending result and
// restores the level registers to their defaults.
module dimmer_frame_receiver_unit #(
    parameter int BUFFER_BYTES = dfr_pkg::BUFFER_BYTES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_frame_status,
    output logic [7:0]  m_proto_version,
    output logic [7:0]  m_frame_command,
    output logic [15:0] m_payload_length,
    output logic        m_send_ack,
    output logic        m_switch_valid,
    output logic        m_switch_on,
    output logic        m_level_valid,
    output logic [7:0]  m_user_level
);

    localparam int CNT_W = $clog2(BUFFER_BYTES + 1);

    typedef enum logic [6:0] {
        PH_HUNT = 7'b0000001,
        PH_SYNC = 7'b0000010,
        PH_VER  = 7'b0000100,
        PH_CMD  = 7'b0001000,
        PH_LENH = 7'b0010000,
        PH_LENL = 7'b0100000,
        PH_BODY = 7'b1000000
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_MAP  = 3'b010,
        ST_DIV  = 3'b100
    } seq_t;

    logic [15:0] raw_min_reg, raw_min_next;
    logic [15:0] raw_max_reg, raw_max_next;
    logic [7:0]  user_range_reg, user_range_next;

    phase_t      phase_reg, phase_next;
    seq_t        seq_reg, seq_next;
    logic [7:0]  version_reg, version_next;
    logic [7:0]  command_reg, command_next;
    logic [15:0] length_reg, length_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]  sum_reg, sum_next;
    logic [7:0]  byte4_reg, byte4_next;
    logic [7:0]  byte6_reg, byte6_next;
    logic [7:0]  byte7_reg, byte7_next;

    logic [23:0] num_reg, num_next;
    logic [23:0] den_reg, den_next;
    logic [7:0]  quo_reg, quo_next;
    logic [2:0]  step_reg, step_next;

    logic        m_valid_reg, m_valid_next;
    logic [1:0]  status_reg, status_next;
    logic [7:0]  out_version_reg, out_version_next;
    logic [7:0]  out_command_reg, out_command_next;
    logic [15:0] out_length_reg, out_length_next;
    logic        ack_reg, ack_next;
    logic        sw_valid_reg, sw_valid_next;
    logic        sw_on_reg, sw_on_next;
    logic        lv_valid_reg, lv_valid_next;
    logic [7:0]  level_reg, level_next;

    logic             in_acc;
    logic [CNT_W-1:0] cnt_inc;
    logic [7:0]       top;
    logic [15:0]      lvl;
    logic [24:0]      trial;
    logic             finish;
    logic [1:0]       fin_status;

    assign cfg_ready = 1'b1;
    assign s_ready   = (seq_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign in_acc    = s_valid && s_ready;
    assign cnt_inc   = count_reg + CNT_W'(1);
    assign top       = (user_range_reg == 8'd0) ? 8'd1 : user_range_reg;
    assign lvl       = {byte6_reg, byte7_reg};
    assign trial     = {1'b0, num_reg} - {1'b0, den_reg};

    always_comb begin
        raw_min_next     = raw_min_reg;
        raw_max_next     = raw_max_reg;
        user_range_next  = user_range_reg;
        phase_next       = phase_reg;
        seq_next         = seq_reg;
        version_next     = version_reg;
        command_next     = command_reg;
        length_next      = length_reg;
        count_next       = count_reg;
        sum_next         = sum_reg;
        byte4_next       = byte4_reg;
        byte6_next       = byte6_reg;
        byte7_next       = byte7_reg;
        num_next         = num_reg;
        den_next         = den_reg;
        quo_next         = quo_reg;
        step_next        = step_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        status_next      = status_reg;
        out_version_next = out_version_reg;
        out_command_next = out_command_reg;
        out_length_next  = out_length_reg;
        ack_next         = ack_reg;
        sw_valid_next    = sw_valid_reg;
        sw_on_next       = sw_on_reg;
        lv_valid_next    = lv_valid_reg;
        level_next       = level_reg;
        finish           = 1'b0;
        fin_status       = dfr_pkg::STATUS_GOOD;

        if (cfg_valid) begin
            case (cfg_index)
                dfr_pkg::REG_RAW_MIN:    raw_min_next    = cfg_data;
                dfr_pkg::REG_RAW_MAX:    raw_max_next    = cfg_data;
                dfr_pkg::REG_USER_RANGE: user_range_next = cfg_data[7:0];
                default: ;
            endcase
        end

        case (seq_reg)
            ST_MAP: begin
                if (lvl <= raw_min_reg) begin
                    level_next   = 8'd1;
                    m_valid_next = 1'b1;
                    seq_next     = ST_IDLE;
                end else if (lvl >= raw_max_reg) begin
                    level_next   = top;
                    m_valid_next = 1'b1;
                    seq_next     = ST_IDLE;
                end else begin
                    num_next  = 24'(lvl - raw_min_reg) * 24'(top - 8'd1);
                    den_next  = {1'b0, raw_max_reg - raw_min_reg, 7'd0};
                    quo_next  = 8'd0;
                    step_next = 3'd7;
                    seq_next  = ST_DIV;
                end
            end
            ST_DIV: begin
                // one quotient bit per cycle, divisor walks down from bit 7
                if (!trial[24]) begin
                    num_next = trial[23:0];
                end
                quo_next  = {quo_reg[6:0], !trial[24]};
                den_next  = den_reg >> 1;
                step_next = step_reg - 3'd1;
                if (step_reg == 3'd0) begin
                    level_next   = quo_next + 8'd1;
                    m_valid_next = 1'b1;
                    seq_next     = ST_IDLE;
                end
            end
            default: begin
                if (in_acc) begin
                    case (phase_reg)
                        PH_SYNC: begin
                            if (s_rx_byte == dfr_pkg::SYNC_SECOND) begin
                                phase_next = PH_VER;
                            end
                        end
                        PH_VER: begin
                            version_next = s_rx_byte;
                            phase_next   = PH_CMD;
                        end
                        PH_CMD: begin
                            command_next = s_rx_byte;
                            phase_next   = PH_LENH;
                        end
                        PH_LENH: begin
                            length_next = {s_rx_byte, 8'h00};
                            phase_next  = PH_LENL;
                        end
                        PH_LENL: begin
                            length_next = {length_reg[15:8], s_rx_byte};
                            sum_next    = dfr_pkg::SUM_SEED + version_reg + command_reg
                                          + s_rx_byte;
                            count_next  = '0;
                            phase_next  = PH_BODY;
                        end
                        PH_BODY: begin
                            if (16'(count_reg) < length_reg) begin
                                sum_next   = sum_reg + s_rx_byte;
                                count_next = cnt_inc;
                                if (count_reg == CNT_W'(dfr_pkg::POS_SWITCH)) begin
                                    byte4_next = s_rx_byte;
                                end
                                if (count_reg == CNT_W'(dfr_pkg::POS_LEVEL_HI)) begin
                                    byte6_next = s_rx_byte;
                                end
                                if (count_reg == CNT_W'(dfr_pkg::POS_LEVEL_LO)) begin
                                    byte7_next = s_rx_byte;
                                end
                                if (32'(cnt_inc) >= BUFFER_BYTES) begin
                                    finish     = 1'b1;
                                    fin_status = dfr_pkg::STATUS_OVERFLOW;
                                end
                            end else begin
                                finish     = 1'b1;
                                fin_status = (s_rx_byte == sum_reg) ? dfr_pkg::STATUS_GOOD
                                                                    : dfr_pkg::STATUS_BAD;
                            end
                        end
                        default: begin
                            if (s_rx_byte == dfr_pkg::SYNC_FIRST) begin
                                phase_next = PH_SYNC;
                            end else if (s_rx_byte == dfr_pkg::SYNC_SECOND) begin
                                phase_next = PH_VER;
                            end else begin
                                phase_next = PH_HUNT;
                            end
                        end
                    endcase

                    if (finish) begin
                        status_next      = fin_status;
                        out_version_next = version_reg;
                        out_command_next = command_reg;
                        out_length_next  = length_reg;
                        ack_next         = 1'b0;
                        sw_valid_next    = 1'b0;
                        sw_on_next       = 1'b0;
                        lv_valid_next    = 1'b0;
                        level_next       = 8'd0;
                        m_valid_next     = 1'b1;
                        if (fin_status == dfr_pkg::STATUS_GOOD) begin
                            if (command_reg == dfr_pkg::CMD_ACK) begin
                                ack_next = 1'b1;
                            end else if (command_reg == dfr_pkg::CMD_REPORT) begin
                                if (length_reg == dfr_pkg::LEN_SWITCH) begin
                                    sw_valid_next = 1'b1;
                                    sw_on_next    = (byte4_reg != 8'd0);
                                end else if (length_reg == dfr_pkg::LEN_LEVEL) begin
                                    // hold the result back until the level is mapped
                                    lv_valid_next = 1'b1;
                                    m_valid_next  = 1'b0;
                                    seq_next      = ST_MAP;
                                end
                            end
                        end
                        phase_next  = PH_HUNT;
                        count_next  = '0;
                        length_next = 16'd0;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            raw_min_reg    <= dfr_pkg::RAW_MIN_RESET;
            raw_max_reg    <= dfr_pkg::RAW_MAX_RESET;
            user_range_reg <= dfr_pkg::USER_RANGE_RESET;
            phase_reg      <= PH_HUNT;
            seq_reg        <= ST_IDLE;
            m_valid_reg    <= 1'b0;
        end else begin
            raw_min_reg    <= raw_min_next;
            raw_max_reg    <= raw_max_next;
            user_range_reg <= user_range_next;
            phase_reg      <= phase_next;
            seq_reg        <= seq_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        version_reg     <= version_next;
        command_reg     <= command_next;
        length_reg      <= length_next;
        count_reg       <= count_next;
        sum_reg         <= sum_next;
        byte4_reg       <= byte4_next;
        byte6_reg       <= byte6_next;
        byte7_reg       <= byte7_next;
        num_reg         <= num_next;
        den_reg         <= den_next;
        quo_reg         <= quo_next;
        step_reg        <= step_next;
        status_reg      <= status_next;
        out_version_reg <= out_version_next;
        out_command_reg <= out_command_next;
        out_length_reg  <= out_length_next;
        ack_reg         <= ack_next;
        sw_valid_reg    <= sw_valid_next;
        sw_on_reg       <= sw_on_next;
        lv_valid_reg    <= lv_valid_next;
        level_reg       <= level_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_frame_status   = status_reg;
    assign m_proto_version  = out_version_reg;
    assign m_frame_command  = out_command_reg;
    assign m_payload_length = out_length_reg;
    assign m_send_ack       = ack_reg;
    assign m_switch_valid   = sw_valid_reg;
    assign m_switch_on      = sw_on_reg;
    assign m_level_valid    = lv_valid_reg;
    assign m_user_level     = level_reg;

endmodule

/* design/dfr_checker.sv */
`include "dimmer_frame_receiver_unit_assert.svh"

module dfr_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_frame_status,
    input logic [15:0] m_payload_length,
    input logic        m_send_ack,
    input logic        m_switch_valid,
    input logic        m_level_valid,
    input logic [7:0]  m_user_level
);

    // a stalled result holds
    `DFR_ASSERT_NEXT(a_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_frame_status) && $stable(m_payload_length) && $stable(m_user_level))

    // flags only on a good frame
    `DFR_ASSERT_NOW(a_flags_good, aclk, aresetn, m_valid && (m_frame_status != dfr_pkg::STATUS_GOOD), !m_send_ack && !m_switch_valid && !m_level_valid)

    // at most one report kind per frame
    `DFR_ASSERT_NOW(a_one_kind, aclk, aresetn, m_valid, $onehot0({m_send_ack, m_switch_valid, m_level_valid}))

    // a mapped level never drops below one
    `DFR_ASSERT_NOW(a_level_min, aclk, aresetn, m_valid && m_level_valid, m_user_level != 8'd0)

endmodule

bind dimmer_frame_receiver_unit dfr_checker u_dfr_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_frame_status   (m_frame_status),
    .m_payload_length (m_payload_length),
    .m_send_ack       (m_send_ack),
    .m_switch_valid   (m_switch_valid),
    .m_level_valid    (m_level_valid),
    .m_user_level     (m_user_level)
);

/* verif/tb_dimmer_frame_receiver_unit.sv */
module tb_dimmer_frame_receiver_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int DEPTH          = dfr_pkg::BUFFER_BYTES_DEF;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int MAX_REPORTS    = 10;
    localparam int PHASE_BYTES    = 105;
    localparam int NUM_PHASES     = 6;

    // ways of opening a frame
    localparam int SYNC_PAIR  = 0;
    localparam int SYNC_LONE  = 1;
    localparam int SYNC_ARMED = 2;

    typedef enum logic [6:0] {
        HUNT        = 7'b0000001,
        GOT_SYNC1   = 7'b0000010,
        GET_VERSION = 7'b0000100,
        GET_COMMAND = 7'b0001000,
        GET_LEN_HI  = 7'b0010000,
        GET_LEN_LO  = 7'b0100000,
        GET_BODY    = 7'b1000000
    } parse_state_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  version;
        logic [7:0]  command;
        logic [15:0] length;
        logic        ack;
        logic        sw_valid;
        logic        sw_on;
        logic        lv_valid;
        logic [7:0]  level;
    } frame_result_t;

    class frame_tracker;
        logic [15:0]   lvl_min;
        logic [15:0]   lvl_max;
        logic [7:0]    lvl_top;
        parse_state_t  phase;
        logic [7:0]    version;
        logic [7:0]    command;
        logic [15:0]   length;
        logic [7:0]    count;
        logic [7:0]    sum;
        logic [7:0]    byte4;
        logic [7:0]    byte6;
        logic [7:0]    byte7;
        frame_result_t pending[$];
        int            errors;
        int            n_status[3];
        int            n_ack;
        int            n_switch;
        int            n_level;

        function new();
            lvl_min = dfr_pkg::RAW_MIN_RESET;
            lvl_max = dfr_pkg::RAW_MAX_RESET;
            lvl_top = dfr_pkg::USER_RANGE_RESET;
            phase   = HUNT;
            version = 8'h00;
            command = 8'h00;
            length  = 16'h0000;
            count   = 8'h00;
            sum     = 8'h00;
            byte4   = 8'h00;
            byte6   = 8'h00;
            byte7   = 8'h00;
            errors  = 0;
            n_ack   = 0;
            n_switch = 0;
            n_level = 0;
            foreach (n_status[i]) n_status[i] = 0;
        endfunction

        function void set_register(logic [1:0] idx, logic [15:0] val);
            case (idx)
                dfr_pkg::REG_RAW_MIN:    lvl_min = val;
                dfr_pkg::REG_RAW_MAX:    lvl_max = val;
                dfr_pkg::REG_USER_RANGE: lvl_top = val[7:0];
                default: ;
            endcase
        endfunction

        function logic [7:0] map_level(int unsigned raw);
            int unsigned lo;
            int unsigned hi;
            int unsigned top;
            lo  = lvl_min;
            hi  = lvl_max;
            top = (lvl_top == 8'h00) ? 1 : lvl_top;
            if (raw <= lo)
                return 8'd1;
            if (raw >= hi)
                return top[7:0];
            return 8'(1 + ((raw - lo) * (top - 1)) / (hi - lo));
        endfunction

        // Note one accepted byte; push the frame result when it closes a frame.
        function void take_byte(logic [7:0] b);
            frame_result_t r;
            case (phase)
                GOT_SYNC1: if (b == dfr_pkg::SYNC_SECOND) phase = GET_VERSION;
                GET_VERSION: begin
                    version = b;
                    phase   = GET_COMMAND;
                end
                GET_COMMAND: begin
                    command = b;
                    phase   = GET_LEN_HI;
                end
                GET_LEN_HI: begin
                    length = {b, 8'h00};
                    phase  = GET_LEN_LO;
                end
                GET_LEN_LO: begin
                    length[7:0] = b;
                    sum   = dfr_pkg::SUM_SEED + version + command + b;
                    count = 8'h00;
                    phase = GET_BODY;
                end
                GET_BODY: begin
                    r = '0;
                    if (16'(count) < length) begin
                        sum = sum + b;
                        if (count == dfr_pkg::POS_SWITCH)   byte4 = b;
                        if (count == dfr_pkg::POS_LEVEL_HI) byte6 = b;
                        if (count == dfr_pkg::POS_LEVEL_LO) byte7 = b;
                        count = count + 8'd1;
                        if (count < DEPTH)
                            return;
                        r.status = dfr_pkg::STATUS_OVERFLOW;
                    end else begin
                        r.status = (b == sum) ? dfr_pkg::STATUS_GOOD : dfr_pkg::STATUS_BAD;
                    end
                    if (r.status == dfr_pkg::STATUS_GOOD) begin
                        if (command == dfr_pkg::CMD_ACK) begin
                            r.ack = 1'b1;
                        end else if (command == dfr_pkg::CMD_REPORT &&
                                     length == dfr_pkg::LEN_SWITCH) begin
                            r.sw_valid = 1'b1;
                            r.sw_on    = (byte4 != 8'h00);
                        end else if (command == dfr_pkg::CMD_REPORT &&
                                     length == dfr_pkg::LEN_LEVEL) begin
                            r.lv_valid = 1'b1;
                            r.level    = map_level({byte6, byte7});
                        end
                    end
                    r.version = version;
                    r.command = command;
                    r.length  = length;
                    pending.push_back(r);
                    phase  = HUNT;
                    count  = 8'h00;
                    length = 16'h0000;
                end
                default: begin
                    if (b == dfr_pkg::SYNC_FIRST)
                        phase = GOT_SYNC1;
                    else if (b == dfr_pkg::SYNC_SECOND)
                        phase = GET_VERSION;
                    else
                        phase = HUNT;
                end
            endcase
        endfunction

        function string describe(frame_result_t r);
            return $sformatf("status=%0d ver=%h cmd=%h len=%h ack=%b switch=%b/%b level=%b/%0d",
                             r.status, r.version, r.command, r.length, r.ack,
                             r.sw_valid, r.sw_on, r.lv_valid, r.level);
        endfunction

        function void note_mismatch(string msg);
            errors++;
            if (errors <= MAX_REPORTS)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endfunction

        function void check_frame(frame_result_t got);
            frame_result_t want;
            if (pending.size() == 0) begin
                note_mismatch({"unexpected frame result: ", describe(got)});
                return;
            end
            want = pending.pop_front();
            if (want.status <= dfr_pkg::STATUS_OVERFLOW)
                n_status[want.status]++;
            n_ack    += want.ack;
            n_switch += want.sw_valid;
            n_level  += want.lv_valid;
            if (got.status !== want.status || got.version !== want.version ||
                got.command !== want.command || got.length !== want.length ||
                got.ack !== want.ack || got.sw_valid !== want.sw_valid ||
                got.sw_on !== want.sw_on || got.lv_valid !== want.lv_valid ||
                got.level !== want.level)
                note_mismatch({"expected ", describe(want), " got ", describe(got)});
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = dfr_pkg::REG_RAW_MIN;
    logic [15:0] cfg_data = 16'h0000;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [7:0]  s_rx_byte = 8'h00;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_frame_status;
    logic [7:0]  m_proto_version;
    logic [7:0]  m_frame_command;
    logic [15:0] m_payload_length;
    logic        m_send_ack;
    logic        m_switch_valid;
    logic        m_switch_on;
    logic        m_level_valid;
    logic [7:0]  m_user_level;

    frame_tracker tracker = new();
    logic [7:0]   body_bytes[$];
    int           sender_idle_pct = 0;
    int           receiver_stall_pct = 0;
    int           bytes_sent = 0;
    int           quiet_cycles = 0;

    dimmer_frame_receiver_unit i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_rx_byte        (s_rx_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_frame_status   (m_frame_status),
        .m_proto_version  (m_proto_version),
        .m_frame_command  (m_frame_command),
        .m_payload_length (m_payload_length),
        .m_send_ack       (m_send_ack),
        .m_switch_valid   (m_switch_valid),
        .m_switch_on      (m_switch_on),
        .m_level_valid    (m_level_valid),
        .m_user_level     (m_user_level)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("[%0t] no item moved for %0d cycles", $realtime, WATCHDOG_LIMIT);
            $display("dimmer_frame_receiver_unit regression: fail");
            $finish;
        end
    end

    // Result side: sample at the edge, then pick the next ready value.
    initial begin
        forever begin
            @(posedge aclk);
            if (m_valid && m_ready)
                tracker.check_frame('{m_frame_status, m_proto_version, m_frame_command,
                                      m_payload_length, m_send_ack, m_switch_valid,
                                      m_switch_on, m_level_valid, m_user_level});
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_byte(input logic [7:0] b);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        tracker.take_byte(b);
        bytes_sent++;
    endtask

    // Drop valid, then step the clock until every result is taken, testing after each edge.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (tracker.pending.size() != 0);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        tracker.set_register(idx, val);
    endtask

    task automatic load_levels(input logic [15:0] lo, input logic [15:0] hi,
                               input logic [7:0] top);
        write_reg(dfr_pkg::REG_RAW_MIN, lo);
        write_reg(dfr_pkg::REG_RAW_MAX, hi);
        write_reg(dfr_pkg::REG_USER_RANGE, {8'h00, top});
        cfg_valid <= 1'b0;
    endtask

    // Bring the parser back to hunting, let every result drain, then hold off.
    task automatic finish_phase();
        while (tracker.phase != HUNT)
            send_byte((tracker.phase == GOT_SYNC1) ? dfr_pkg::SYNC_SECOND : 8'h00);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic fill_body(input int n);
        body_bytes.delete();
        repeat (n) body_bytes.push_back(8'($urandom));
    endtask

    // sync_style: SYNC_PAIR sends 55 AA, SYNC_LONE a lone AA, SYNC_ARMED 55, junk, AA
    task automatic send_frame(input logic [7:0] ver, input logic [7:0] cmd,
                              input logic [15:0] len, input bit bad_sum,
                              input int sync_style);
        logic [7:0] sum;
        logic [7:0] junk;
        case (sync_style)
            SYNC_PAIR: begin
                send_byte(dfr_pkg::SYNC_FIRST);
                send_byte(dfr_pkg::SYNC_SECOND);
            end
            SYNC_LONE: send_byte(dfr_pkg::SYNC_SECOND);
            default: begin
                send_byte(dfr_pkg::SYNC_FIRST);
                repeat ($urandom_range(3, 1)) begin
                    do junk = 8'($urandom); while (junk == dfr_pkg::SYNC_SECOND);
                    send_byte(junk);
                end
                send_byte(dfr_pkg::SYNC_SECOND);
            end
        endcase
        send_byte(ver);
        send_byte(cmd);
        send_byte(len[15:8]);
        send_byte(len[7:0]);
        sum = dfr_pkg::SUM_SEED + ver + cmd + len[7:0];
        foreach (body_bytes[i]) begin
            sum = sum + body_bytes[i];
            send_byte(body_bytes[i]);
        end
        if (len < DEPTH)
            send_byte(bad_sum ? sum ^ 8'($urandom_range(255, 1)) : sum);
    endtask

    task automatic send_random_frame();
        int          pick;
        logic [15:0] len;
        logic [7:0]  cmd;
        logic [15:0] raw;
        logic [15:0] lo;
        logic [15:0] hi;
        pick = $urandom_range(99);
        cmd  = 8'($urandom);
        lo   = tracker.lvl_min;
        hi   = tracker.lvl_max;
        if ($urandom_range(5) == 0)
            repeat ($urandom_range(3, 1)) send_byte(8'($urandom));
        if (pick < 15) begin
            cmd = dfr_pkg::CMD_ACK;
            len = 16'($urandom_range(3));
        end else if (pick < 35) begin
            cmd = dfr_pkg::CMD_REPORT;
            len = dfr_pkg::LEN_SWITCH;
        end else if (pick < 60) begin
            cmd = dfr_pkg::CMD_REPORT;
            len = dfr_pkg::LEN_LEVEL;
        end else if (pick < 70) begin
            cmd = dfr_pkg::CMD_REPORT;
            len = 16'($urandom_range(12));
        end else if (pick < 92) begin
            len = ($urandom_range(4) == 0) ? 16'($urandom_range(DEPTH - 1)) :
                                             16'($urandom_range(10));
        end else if (pick < 97) begin
            len = ($urandom_range(1) == 0) ? 16'(DEPTH) : 16'($urandom_range(65535, DEPTH));
        end else begin
            // broken frame: header cut short, later bytes get absorbed into it
            send_byte(dfr_pkg::SYNC_FIRST);
            send_byte(dfr_pkg::SYNC_SECOND);
            repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
            return;
        end
        fill_body((len < DEPTH) ? int'(len) : DEPTH);
        if (len == dfr_pkg::LEN_SWITCH && $urandom_range(1) == 0)
            body_bytes[dfr_pkg::POS_SWITCH] = 8'h00;
        if (len == dfr_pkg::LEN_LEVEL) begin
            case ($urandom_range(7))
                0: raw = lo;
                1: raw = hi;
                2: raw = lo + 16'd1;
                3: raw = hi - 16'd1;
                4: raw = 16'h0000;
                5: raw = 16'hFFFF;
                6: raw = 16'($urandom);
                default: raw = 16'($urandom_range(hi, lo));
            endcase
            body_bytes[dfr_pkg::POS_LEVEL_HI] = raw[15:8];
            body_bytes[dfr_pkg::POS_LEVEL_LO] = raw[7:0];
        end
        send_frame(8'($urandom), cmd, len, $urandom_range(7) == 0,
                   $urandom_range(SYNC_ARMED, SYNC_PAIR));
    endtask

    initial begin
        logic [15:0] lo;
        logic [15:0] hi;
        logic [7:0]  top;
        int          phase_start;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;

        // directed frames on the reset level settings
        fill_body(0);
        send_frame(8'hFF, dfr_pkg::CMD_ACK, 16'd0, 1'b0, SYNC_PAIR);
        fill_body(5);
        body_bytes[dfr_pkg::POS_SWITCH] = 8'hFF;
        send_frame(8'h00, dfr_pkg::CMD_REPORT, dfr_pkg::LEN_SWITCH, 1'b0, SYNC_LONE);
        fill_body(8);
        body_bytes[dfr_pkg::POS_LEVEL_HI] = 8'h01;
        body_bytes[dfr_pkg::POS_LEVEL_LO] = 8'hF4;
        send_frame(8'h80, dfr_pkg::CMD_REPORT, dfr_pkg::LEN_LEVEL, 1'b0, SYNC_ARMED);
        body_bytes[dfr_pkg::POS_LEVEL_HI] = 8'hFF;
        body_bytes[dfr_pkg::POS_LEVEL_LO] = 8'hFF;
        send_frame(8'h5A, dfr_pkg::CMD_REPORT, dfr_pkg::LEN_LEVEL, 1'b0, SYNC_PAIR);
        body_bytes[dfr_pkg::POS_LEVEL_HI] = 8'h00;
        body_bytes[dfr_pkg::POS_LEVEL_LO] = 8'h00;
        send_frame(8'hA5, dfr_pkg::CMD_REPORT, dfr_pkg::LEN_LEVEL, 1'b0, SYNC_PAIR);
        fill_body(0);
        send_frame(8'h01, dfr_pkg::CMD_ACK, 16'd0, 1'b1, SYNC_PAIR);
        fill_body(DEPTH);
        send_frame(8'h01, dfr_pkg::CMD_REPORT, 16'hFFFF, 1'b0, SYNC_PAIR);

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            finish_phase();
            case (ph)
                0: begin lo = 16'd0;     hi = 16'd1000;  top = 8'd200; end
                1: begin lo = 16'h0000;  hi = 16'hFFFF;  top = 8'd255; end
                2: begin lo = 16'hFFFF;  hi = 16'h0000;  top = 8'd1;   end
                3: begin lo = 16'd100;   hi = 16'd101;   top = 8'd255; end
                4: begin lo = 16'd500;   hi = 16'd500;   top = 8'd0;   end
                default: begin
                    lo  = 16'($urandom_range(60000));
                    hi  = lo + 16'($urandom_range(5000, 1));
                    top = 8'($urandom_range(255, 1));
                end
            endcase
            load_levels(lo, hi, top);
            case (ph % 4)
                0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
                1: begin sender_idle_pct = 52; receiver_stall_pct = 0;  end
                2: begin sender_idle_pct = 0;  receiver_stall_pct = 52; end
                default: begin sender_idle_pct = 32; receiver_stall_pct = 32; end
            endcase
            phase_start = bytes_sent;
            while (bytes_sent - phase_start < PHASE_BYTES) begin
                send_random_frame();
                if ($urandom_range(39) == 0)
                    wait_for_results();
            end
        end
        finish_phase();

        $display("run covered %0d bytes over %0d level settings:", bytes_sent,
                 NUM_PHASES + 1);
        $display("  %0d good, %0d bad-sum, %0d overflow frames; %0d ack, %0d switch, %0d level",
                 tracker.n_status[dfr_pkg::STATUS_GOOD], tracker.n_status[dfr_pkg::STATUS_BAD],
                 tracker.n_status[dfr_pkg::STATUS_OVERFLOW], tracker.n_ack,
                 tracker.n_switch, tracker.n_level);
        if (tracker.errors == 0 && tracker.pending.size() == 0) begin
            $display("dimmer_frame_receiver_unit regression: pass");
        end else begin
            $display("dimmer_frame_receiver_unit regression: fail");
        end
        $finish;
    end

endmodule
